// ===== rtl/core/ortho_rectify_source_address_top_assert.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ORTHO_RECTIFY_SOURCE_ADDRESS_TOP_ASSERT_SVH
`define ORTHO_RECTIFY_SOURCE_ADDRESS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ORSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ORSA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ORSA_ASSERT(lbl, prop)
`define ORSA_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== rtl/core/orsa_pkg.sv =====
package orsa_pkg;

  localparam int NUM_STAGES = 12;
  localparam int DIV_STAGES = 6;
  localparam logic [12:0] MAX_DIM = 13'd4096;

  localparam logic [2:0] REG_X_TERMS = 3'd0;
  localparam logic [2:0] REG_Y_TERMS = 3'd1;
  localparam logic [2:0] REG_Z_TERMS = 3'd2;
  localparam logic [2:0] REG_FOCAL = 3'd3;
  localparam logic [2:0] REG_SRC_COLS = 3'd4;
  localparam logic [2:0] REG_SRC_ROWS = 3'd5;

  typedef struct packed {
    logic [11:0] out_col;
    logic [11:0] out_row;
  } in_beat_t;

  typedef struct packed {
    logic [11:0] src_col;
    logic [11:0] src_row;
    logic        inside_res;
  } out_beat_t;

  typedef struct packed {
    logic [55:0] rc;
    logic [55:0] rr;
    logic [54:0] dd;
    logic [11:0] qc;
    logic [11:0] qr;
    logic        ins;
  } div_t;

endpackage

// ===== rtl/core/orsa_div2.sv =====
module orsa_div2 (
  input  logic          clk,
  input  logic          en,
  input  orsa_pkg::div_t d_in,
  output orsa_pkg::div_t d_out_r
);
  import orsa_pkg::*;

  div_t d_nxt;

  always_comb begin
    logic [55:0] rc;
    logic [55:0] rr;
    logic [11:0] qc;
    logic [11:0] qr;
    rc = d_in.rc;
    rr = d_in.rr;
    qc = d_in.qc;
    qr = d_in.qr;
    for (int i = 0; i < 2; i++) begin
      if (rc >= {1'b0, d_in.dd}) begin
        rc = rc - {1'b0, d_in.dd};
        qc = {qc[10:0], 1'b1};
      end else begin
        qc = {qc[10:0], 1'b0};
      end
      if (rr >= {1'b0, d_in.dd}) begin
        rr = rr - {1'b0, d_in.dd};
        qr = {qr[10:0], 1'b1};
      end else begin
        qr = {qr[10:0], 1'b0};
      end
      rc = {rc[54:0], 1'b0};
      rr = {rr[54:0], 1'b0};
    end
    d_nxt = d_in;
    d_nxt.rc = rc;
    d_nxt.rr = rr;
    d_nxt.qc = qc;
    d_nxt.qr = qr;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out_r <= d_nxt;
    end
  end

endmodule

// ===== rtl/core/ortho_rectify_source_address_top.sv =====
// Ortho-rectification source address generator.
// The input channel (in_valid, in_ready, in_data) takes one output grid
// pixel per beat; the result channel (out_valid, out_ready, out_data) gives
// the nearest source pixel and an inside flag for each, in order.
// The configuration port writes one register per cycle on cfg_we, by
// cfg_index; the user must write it only while the block is idle (not enforced).
// The block is a 12-stage pipeline: six stages of projection arithmetic
// (products, sums, focal multiply, scaling, offset, bounds) and six stages
// of a restoring divider that resolve two quotient bits each.
// Throughput is one beat per cycle while the receiver does not stall.
// When the receiver stalls, a full stage holds its beat only while every
// stage ahead of it is full too, so bubbles are squeezed out and input is
// still taken while any stage is empty.
// Synchronous reset clears all valid bits and sets the configuration
// registers to their reset values.
module ortho_rectify_source_address_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  orsa_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output orsa_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import orsa_pkg::*;

  logic [63:0] x_terms_r, y_terms_r, z_terms_r;
  logic [23:0] focal_r;
  logic [12:0] cols_r, rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_terms_r <= '0;
      y_terms_r <= '0;
      z_terms_r <= '0;
      focal_r <= '0;
      cols_r <= MAX_DIM;
      rows_r <= MAX_DIM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_TERMS:  x_terms_r <= cfg_data;
        REG_Y_TERMS:  y_terms_r <= cfg_data;
        REG_Z_TERMS:  z_terms_r <= cfg_data;
        REG_FOCAL:    focal_r <= cfg_data[23:0];
        REG_SRC_COLS: cols_r <= cfg_data[12:0];
        REG_SRC_ROWS: rows_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  logic [12:0] cdim, rdim;
  assign cdim = (cols_r > MAX_DIM) ? MAX_DIM : cols_r;
  assign rdim = (rows_r > MAX_DIM) ? MAX_DIM : rows_r;

  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 1: column and row products.
  logic signed [12:0] col_s, row_s;
  logic signed [32:0] pxc_r, pxr_r, pyc_r, pyr_r, pzc_r, pzr_r;
  assign col_s = $signed({1'b0, in_data.out_col});
  assign row_s = $signed({1'b0, in_data.out_row});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pxc_r <= col_s * $signed(x_terms_r[43:24]);
      pxr_r <= row_s * $signed(x_terms_r[63:44]);
      pyc_r <= col_s * $signed(y_terms_r[43:24]);
      pyr_r <= row_s * $signed(y_terms_r[63:44]);
      pzc_r <= col_s * $signed(z_terms_r[43:24]);
      pzr_r <= row_s * $signed(z_terms_r[63:44]);
    end
  end

  // Stage 2: affine sums.
  logic signed [35:0] x_r, y_r, z_r;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      x_r <= 36'($signed(x_terms_r[23:0])) + 36'(pxc_r) + 36'(pxr_r);
      y_r <= 36'($signed(y_terms_r[23:0])) + 36'(pyc_r) + 36'(pyr_r);
      z_r <= 36'($signed(z_terms_r[23:0])) + 36'(pzc_r) + 36'(pzr_r);
    end
  end

  // Stage 3: focal multiply and depth magnitude.
  logic signed [24:0] f_s;
  logic signed [60:0] fx_r, fy_r;
  logic [43:0] den_r3;
  logic        zneg_r3, zz_r3;
  logic [35:0] zabs;
  assign f_s = $signed({1'b0, focal_r});
  assign zabs = z_r[35] ? 36'(-z_r) : 36'(z_r);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      fx_r <= f_s * x_r;
      fy_r <= f_s * y_r;
      den_r3 <= {zabs, 8'd0};
      zneg_r3 <= z_r[35];
      zz_r3 <= (z_r == '0);
    end
  end

  // Stage 4: sign fold and scaled image offsets and bounds.
  logic signed [63:0] nc_r4, nr_r4;
  logic [56:0] hcd_r4, hrd_r4, cdd_r4, rdd_r4;
  logic [43:0] den_r4;
  logic        bad_r4;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      nc_r4 <= zneg_r3 ? 64'(fx_r) : -64'(fx_r);
      nr_r4 <= zneg_r3 ? -64'(fy_r) : 64'(fy_r);
      hcd_r4 <= {1'b0, cdim[12:1]} * den_r3;
      hrd_r4 <= {1'b0, rdim[12:1]} * den_r3;
      cdd_r4 <= cdim * den_r3;
      rdd_r4 <= rdim * den_r3;
      den_r4 <= den_r3;
      bad_r4 <= zz_r3 || (cdim == '0) || (rdim == '0);
    end
  end

  // Stage 5: numerators.
  logic signed [63:0] nc_r5, nr_r5;
  logic [56:0] cdd_r5, rdd_r5;
  logic [43:0] den_r5;
  logic        bad_r5;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      nc_r5 <= nc_r4 + $signed({7'd0, hcd_r4});
      nr_r5 <= nr_r4 + $signed({7'd0, hrd_r4});
      cdd_r5 <= cdd_r4;
      rdd_r5 <= rdd_r4;
      den_r5 <= den_r4;
      bad_r5 <= bad_r4;
    end
  end

  // Stage 6: bounds check and divider setup.
  logic signed [63:0] nden;
  logic ins_c, ins_r, ins;
  div_t div_nxt;
  div_t div_r [DIV_STAGES+1];

  assign nden = -$signed({20'd0, den_r5});
  assign ins_c = (nc_r5 > nden) && (nc_r5 < $signed({7'd0, cdd_r5}));
  assign ins_r = (nr_r5 > nden) && (nr_r5 < $signed({7'd0, rdd_r5}));
  assign ins = !bad_r5 && ins_c && ins_r;

  always_comb begin
    div_nxt.rc = (ins && !nc_r5[63]) ? nc_r5[55:0] : '0;
    div_nxt.rr = (ins && !nr_r5[63]) ? nr_r5[55:0] : '0;
    div_nxt.dd = {den_r5, 11'd0};
    div_nxt.qc = '0;
    div_nxt.qr = '0;
    div_nxt.ins = ins;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      div_r[0] <= div_nxt;
    end
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    orsa_div2 u_div (
      .clk    (clk),
      .en     (en[g+6]),
      .d_in   (div_r[g]),
      .d_out_r(div_r[g+1])
    );
  end

  assign out_valid = v_r[NUM_STAGES-1];
  assign out_data.src_col = div_r[DIV_STAGES].ins ? div_r[DIV_STAGES].qc : '0;
  assign out_data.src_row = div_r[DIV_STAGES].ins ? div_r[DIV_STAGES].qr : '0;
  assign out_data.inside_res = div_r[DIV_STAGES].ins;

`include "ortho_rectify_source_address_top_assert.svh"

  `ORSA_ASSERT(a_outside_zero, out_valid && !out_data.inside_res |-> out_data.src_col == '0 && out_data.src_row == '0)
  `ORSA_ASSERT(a_ready_when_drained, !v_r[NUM_STAGES-1] |-> in_ready)
  `ORSA_ASSERT_RST(a_reset_clears, !rst_n |=> !out_valid)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import orsa_pkg::*;

  localparam int LATENCY = NUM_STAGES;
  localparam int IDLE_LIMIT = 4000;
  localparam int PHASES = 10;
  localparam int PHASE_BEATS = 75;

  class addr_scoreboard;
    logic [63:0] x_terms, y_terms, z_terms;
    logic [23:0] focal;
    logic [12:0] cols_reg, rows_reg;
    out_beat_t   pending_addr[$];
    int          errors;

    function new();
      x_terms = '0;
      y_terms = '0;
      z_terms = '0;
      focal = '0;
      cols_reg = 13'd4096;
      rows_reg = 13'd4096;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        REG_X_TERMS: x_terms = val;
        REG_Y_TERMS: y_terms = val;
        REG_Z_TERMS: z_terms = val;
        REG_FOCAL: focal = val[23:0];
        REG_SRC_COLS: cols_reg = val[12:0];
        REG_SRC_ROWS: rows_reg = val[12:0];
        default: ;
      endcase
    endfunction

    function longint affine(logic [63:0] p, longint c, longint r);
      longint b0, cs, rs;
      b0 = longint'($signed(p[23:0]));
      cs = longint'($signed(p[43:24]));
      rs = longint'($signed(p[63:44]));
      return b0 + c * cs + r * rs;
    endfunction

    function out_beat_t project(in_beat_t b);
      longint c, r, x, y, z, f, cols, rows, den, nc, nr, tc, tr;
      out_beat_t res;
      c = longint'(b.out_col);
      r = longint'(b.out_row);
      x = affine(x_terms, c, r);
      y = affine(y_terms, c, r);
      z = affine(z_terms, c, r);
      f = longint'(focal);
      cols = (cols_reg > MAX_DIM) ? longint'(MAX_DIM) : longint'(cols_reg);
      rows = (rows_reg > MAX_DIM) ? longint'(MAX_DIM) : longint'(rows_reg);
      res = '0;
      if (z != 0) begin
        den = z * 256;
        nc = -(f * x);
        nr = f * y;
        if (den < 0) begin
          den = -den;
          nc = -nc;
          nr = -nr;
        end
        tc = ((cols / 2) * den + nc) / den;
        tr = ((rows / 2) * den + nr) / den;
        if (tc >= 0 && tc < cols && tr >= 0 && tr < rows) begin
          res.src_col = tc[11:0];
          res.src_row = tr[11:0];
          res.inside_res = 1'b1;
        end
      end
      return res;
    endfunction

    function void note_input(in_beat_t b);
      pending_addr.push_back(project(b));
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(out_beat_t got);
      out_beat_t want;
      if (pending_addr.size() == 0) begin
        report($sformatf("unexpected beat %h", got));
      end else begin
        want = pending_addr.pop_front();
        if (got.src_col !== want.src_col)
          report($sformatf("src_col %0d, expected %0d", got.src_col, want.src_col));
        if (got.src_row !== want.src_row)
          report($sformatf("src_row %0d, expected %0d", got.src_row, want.src_row));
        if (got.inside_res !== want.inside_res)
          report($sformatf("inside_res %0b, expected %0b", got.inside_res,
                           want.inside_res));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_beat_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_beat_t  out_data;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  addr_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  calm = 1'b0;
  int  stall_left = 0;

  always #5 clk = ~clk;

  ortho_rectify_source_address_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
    end
  end

  function int pick_gap();
    if (calm || $urandom_range(0, 2) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task send_pixel(logic [11:0] c, logic [11:0] r, int gap);
    in_beat_t b;
    b.out_col = c;
    b.out_row = r;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task drain_pipe();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_addr.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task write_cfg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function logic [63:0] pack_terms(int b0, int cs, int rs);
    logic [23:0] bb;
    logic [19:0] cc, rr;
    bb = b0[23:0];
    cc = cs[19:0];
    rr = rs[19:0];
    return {rr, cc, bb};
  endfunction

  task load_setup(logic [63:0] x, logic [63:0] y, logic [63:0] z, logic [23:0] f,
                  logic [12:0] cw, logic [12:0] rh);
    write_cfg(REG_X_TERMS, x);
    write_cfg(REG_Y_TERMS, y);
    write_cfg(REG_Z_TERMS, z);
    write_cfg(REG_FOCAL, {40'd0, f});
    write_cfg(REG_SRC_COLS, {51'd0, cw});
    write_cfg(REG_SRC_ROWS, {51'd0, rh});
  endtask

  function int srand(int lim);
    return $signed($urandom_range(0, 2 * lim)) - lim;
  endfunction

  task random_setup();
    logic [12:0] cw, rh;
    int zb;
    case ($urandom_range(0, 5))
      0: cw = 13'($urandom_range(0, 8191));
      1: cw = 13'd4096;
      2: cw = 13'd1;
      default: cw = 13'($urandom_range(16, 4096));
    endcase
    case ($urandom_range(0, 5))
      0: rh = 13'($urandom_range(0, 8191));
      1: rh = 13'd4096;
      2: rh = 13'd1;
      default: rh = 13'($urandom_range(16, 4096));
    endcase
    if ($urandom_range(0, 4) == 0) begin
      load_setup({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 24'($urandom), cw, rh);
    end else begin
      zb = $urandom_range(100000, 8388607);
      if ($urandom_range(0, 3) == 0) zb = -zb;
      load_setup(pack_terms(srand(8388607), srand(2000), srand(2000)),
                 pack_terms(srand(8388607), srand(2000), srand(2000)),
                 pack_terms(zb, srand(30), srand(30)),
                 24'($urandom_range(0, 65535)), cw, rh);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values give every pixel zero depth.
    send_pixel(12'd0, 12'd0, 0);
    send_pixel(12'hFFF, 12'hFFF, 0);
    drain_pipe();

    // Zero focal length lands on the image center.
    load_setup(pack_terms(1000, 3, -2), pack_terms(-500, 1, 1), pack_terms(4096, 0, 0),
               24'd0, 13'd640, 13'd481);
    send_pixel(12'd0, 12'd0, 0);
    send_pixel(12'hFFF, 12'd0, 1);
    send_pixel(12'd0, 12'hFFF, 0);
    drain_pipe();

    // A quotient just below zero truncates to zero and stays inside.
    load_setup(pack_terms(128, 0, 0), pack_terms(-128, 0, 0), pack_terms(256, 0, 0),
               24'd256, 13'd1, 13'd1);
    send_pixel(12'd0, 12'd0, 0);
    send_pixel(12'd5, 12'd9, 0);
    drain_pipe();

    // Negative depth, saturated dimensions and column-dependent zero depth.
    load_setup(pack_terms(-8388608, 524287, -524288), pack_terms(8388607, -524288, 524287),
               pack_terms(-4095, 1, 0), 24'hFFFFFF, 13'd8191, 13'd4097);
    send_pixel(12'd4095, 12'd0, 0);
    send_pixel(12'd0, 12'd0, 0);
    send_pixel(12'd4095, 12'd4095, 2);
    send_pixel(12'd1, 12'd2048, 0);
    drain_pipe();

    // Zero dimensions leave nothing inside; bad indexes must be ignored.
    load_setup(pack_terms(0, 0, 0), pack_terms(0, 0, 0), pack_terms(256, 0, 0),
               24'd256, 13'd0, 13'd0);
    write_cfg(3'd6, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cfg(3'd7, 64'h1234_5678_9ABC_DEF0);
    send_pixel(12'd0, 12'd0, 0);
    send_pixel(12'd100, 12'd100, 0);
    drain_pipe();

    for (int p = 0; p < PHASES; p++) begin
      random_setup();
      calm = (p % 4 == 3);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if ($urandom_range(0, 3) == 0)
          send_pixel(12'($urandom_range(0, 15)), 12'($urandom_range(0, 15)), pick_gap());
        else
          send_pixel(12'($urandom), 12'($urandom), pick_gap());
      end
      drain_pipe();
    end
    calm = 1'b0;

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
